// ===== rtl/core/dedup_fifo_with_membership_bitmap_top_assert.svh =====
// Assertion macros for the dedup FIFO block.
// Used by dfmb_back; needs clk and rst_n in scope.
`ifndef DEDUP_FIFO_WITH_MEMBERSHIP_BITMAP_TOP_ASSERT_SVH
`define DEDUP_FIFO_WITH_MEMBERSHIP_BITMAP_TOP_ASSERT_SVH

// checked only out of reset
`define DFMB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DFMB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dfmb_pkg.sv =====
// Shared types and constants for the dedup FIFO block.
// No dependencies.
package dfmb_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int VALUE_RANGE = 4096;
    localparam int WORD_BITS   = 64;
    localparam int MAP_WORDS   = (VALUE_RANGE + WORD_BITS - 1) / WORD_BITS;

    localparam int CMD_W   = 3;
    localparam int VAL_W   = 12;
    localparam int STAT_W  = 3;
    localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = QIDX_W + 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int MWORD_W = VAL_W - BIT_W;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOWEST   = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_DUP   = 3'd2,
        ST_EMPTY = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_POP,
        OP_CONTAINS,
        OP_CLEAR,
        OP_LOWEST,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             range_err;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } qhead_t;

endpackage

// ===== rtl/core/dfmb_front.sv =====
// Front end: decodes and range-checks requests, buffers them in a 2-entry queue.
// Depends on dfmb_pkg.
module dfmb_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [dfmb_pkg::CMD_W-1:0] cmd,
    input  logic [dfmb_pkg::VAL_W-1:0] value,
    output dfmb_pkg::qhead_t           qhead,
    input  logic                       qpop
);
    import dfmb_pkg::*;

    req_t       ent_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    req_t       dec;
    logic       push, pop;

    always_comb
    begin
        dec.value     = value;
        dec.range_err = ({1'b0, value} >= (VAL_W+1)'(VALUE_RANGE));
        unique case (cmd)
            CMD_ADD:      dec.op = OP_ADD;
            CMD_POP:      dec.op = OP_POP;
            CMD_CONTAINS: dec.op = OP_CONTAINS;
            CMD_CLEAR:    dec.op = OP_CLEAR;
            CMD_LOWEST:   dec.op = OP_LOWEST;
            default:      dec.op = OP_NOP;
        endcase
    end

    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign pop        = qpop && (cnt_reg != 2'd0);
    assign qhead.valid = (cnt_reg != 2'd0);
    assign qhead.req   = ent_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/dfmb_back.sv =====
// Back end: ring store, bitmap memory with per-word nonzero flags, command sequencer
// and output register. Depends on dfmb_pkg and the assertion macro header.
`include "dedup_fifo_with_membership_bitmap_top_assert.svh"
module dfmb_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfmb_pkg::qhead_t            qhead,
    output logic                        qpop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dfmb_pkg::STAT_W-1:0] status,
    output logic [dfmb_pkg::VAL_W-1:0]  out_value,
    output logic                        present,
    output logic [dfmb_pkg::CNT_W-1:0]  item_count
);
    import dfmb_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_POP_RD, S_EXEC} state_t;

    state_t               state_reg, state_next;
    req_t                 cur_reg;
    logic [QIDX_W-1:0]    head_reg, tail_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [MAP_WORDS-1:0] nz_reg;
    logic [MWORD_W-1:0]   widx_reg, rd_addr, low_idx;
    logic                 rd_nz_reg;
    logic [WORD_BITS-1:0] rd_word_reg, word, mask, new_word;
    logic [VAL_W-1:0]     rd_ring_reg, tgt;
    logic [BIT_W-1:0]     low_bit;
    logic                 out_free, do_exec, rd_en;

    logic [VAL_W-1:0]     ring_mem [QUEUE_DEPTH];
    logic [WORD_BITS-1:0] bm_mem   [MAP_WORDS];
    logic                 ring_we, bm_we;

    logic                 ovalid_reg;
    status_t              stat_reg;
    logic [VAL_W-1:0]     oval_reg;
    logic                 pres_reg;
    status_t              stat_c;
    logic [VAL_W-1:0]     oval_c;
    logic                 pres_c;

    always_comb
    begin
        low_idx = '0;
        for (int i = MAP_WORDS - 1; i >= 0; i--)
        begin
            if (nz_reg[i])
            begin
                low_idx = MWORD_W'(i);
            end
        end
        low_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                low_bit = BIT_W'(i);
            end
        end
    end

    assign out_free = !ovalid_reg || !out_stall;
    assign do_exec  = (state_reg == S_EXEC) && out_free;
    assign qpop     = (state_reg == S_IDLE) && qhead.valid;
    assign word     = rd_nz_reg ? rd_word_reg : '0;
    assign tgt      = (cur_reg.op == OP_POP) ? rd_ring_reg : cur_reg.value;
    assign mask     = WORD_BITS'(1) << tgt[BIT_W-1:0];

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (state_reg == S_IDLE)
        begin
            rd_en   = 1'b1;
            rd_addr = (qhead.req.op == OP_LOWEST) ? low_idx
                                                  : qhead.req.value[VAL_W-1:BIT_W];
        end
        else if (state_reg == S_POP_RD)
        begin
            rd_en   = 1'b1;
            rd_addr = rd_ring_reg[VAL_W-1:BIT_W];
        end
    end

    always_comb
    begin
        stat_c   = ST_OK;
        oval_c   = '0;
        pres_c   = 1'b0;
        ring_we  = 1'b0;
        bm_we    = 1'b0;
        new_word = word;
        case (cur_reg.op)
            OP_ADD:
            begin
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    stat_c = ST_FULL;
                end
                else if (cur_reg.range_err)
                begin
                    stat_c = ST_RANGE;
                end
                else if ((word & mask) != '0)
                begin
                    stat_c = ST_DUP;
                end
                else
                begin
                    ring_we  = do_exec;
                    bm_we    = do_exec;
                    new_word = word | mask;
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                begin
                    stat_c = ST_EMPTY;
                end
                else
                begin
                    oval_c   = rd_ring_reg;
                    bm_we    = do_exec;
                    new_word = word & ~mask;
                end
            end
            OP_CONTAINS:
            begin
                if (cur_reg.range_err)
                begin
                    stat_c = ST_RANGE;
                end
                else
                begin
                    pres_c = ((word & mask) != '0);
                end
            end
            OP_LOWEST:
            begin
                if (nz_reg == '0)
                begin
                    stat_c = ST_EMPTY;
                end
                else
                begin
                    oval_c = {widx_reg, low_bit};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[tail_reg] <= cur_reg.value;
        end
        if (state_reg == S_IDLE)
        begin
            rd_ring_reg <= ring_mem[head_reg];
        end
        if (bm_we)
        begin
            bm_mem[widx_reg] <= new_word;
        end
        if (rd_en)
        begin
            rd_word_reg <= bm_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (qhead.valid)
                begin
                    state_next = (qhead.req.op == OP_POP) ? S_POP_RD : S_EXEC;
                end
            end
            S_POP_RD: state_next = S_EXEC;
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            nz_reg     <= '0;
            ovalid_reg <= 1'b0;
            rd_nz_reg  <= 1'b0;
            widx_reg   <= '0;
            cur_reg    <= '{op: OP_NOP, range_err: 1'b0, value: '0};
            stat_reg   <= ST_OK;
            oval_reg   <= '0;
            pres_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (qpop)
            begin
                cur_reg <= qhead.req;
            end
            if (rd_en)
            begin
                rd_nz_reg <= nz_reg[rd_addr];
                widx_reg  <= rd_addr;
            end
            if (out_free)
            begin
                ovalid_reg <= 1'b0;
            end
            if (do_exec)
            begin
                ovalid_reg <= 1'b1;
                stat_reg   <= stat_c;
                oval_reg   <= oval_c;
                pres_reg   <= pres_c;
                if (bm_we)
                begin
                    nz_reg[widx_reg] <= (new_word != '0);
                end
                if (ring_we)
                begin
                    tail_reg  <= tail_reg + 1'b1;
                    count_reg <= count_reg + 1'b1;
                end
                if (cur_reg.op == OP_POP && stat_c == ST_OK)
                begin
                    head_reg  <= head_reg + 1'b1;
                    count_reg <= count_reg - 1'b1;
                end
                if (cur_reg.op == OP_CLEAR)
                begin
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    count_reg <= '0;
                    nz_reg    <= '0;
                end
            end
        end
    end

    assign out_valid  = ovalid_reg;
    assign status     = stat_reg;
    assign out_value  = oval_reg;
    assign present    = pres_reg;
    assign item_count = count_reg;

    `DFMB_ASSERT(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "count above depth")
    `DFMB_ASSERT(a_ptr_count, (QIDX_W'(tail_reg - head_reg) == count_reg[QIDX_W-1:0]), "pointers disagree with count")
    `DFMB_ASSERT(a_pop_rd_seq, (state_reg == S_POP_RD) |-> $past(state_reg == S_IDLE), "pop read out of sequence")
    `DFMB_ASSERT(a_empty_no_bits, (count_reg == '0 && state_reg == S_IDLE) |-> (nz_reg == '0), "bitmap set while empty")

endmodule

// ===== rtl/core/dedup_fifo_with_membership_bitmap_top.sv =====
// Result registered after the sequencer's bitmap read and execute states; a pop first
// reads the ring store. The sequencer finishes each request (memory read, then
// read-modify-write) before the next; lowest member uses per-word nonzero flags.
// A 2-entry request queue decouples input from the sequencer; output is registered.
// Reset: asynchronous, clears pointers, count and bitmap flags at once; no clearing pass.
module dedup_fifo_with_membership_bitmap_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dfmb_pkg::CMD_W-1:0]  cmd,
    input  logic [dfmb_pkg::VAL_W-1:0]  value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dfmb_pkg::STAT_W-1:0] status,
    output logic [dfmb_pkg::VAL_W-1:0]  out_value,
    output logic                        present,
    output logic [dfmb_pkg::CNT_W-1:0]  item_count
);
    import dfmb_pkg::*;

    qhead_t qhead;
    logic   qpop;

    dfmb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .value    (value),
        .qhead    (qhead),
        .qpop     (qpop)
    );

    dfmb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qhead      (qhead),
        .qpop       (qpop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_value  (out_value),
        .present    (present),
        .item_count (item_count)
    );

endmodule
